// File: hw/rtl/assert_macros.svh
// Assertion macros for the checker file of this block.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, masked while reset is high.
`define ASSERT_NOW(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, masked while reset is high.
`define ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

// Next-cycle implication that also holds across reset.
`define ASSERT_ALWAYS_NEXT(name, clk, ante, cons) \
  name: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: hw/rtl/u8250_pkg.sv
// Types and constants of the 8250-style UART register model.
// No dependencies; used by the core, the top level and the testbench.
package u8250_pkg;

  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_RX    = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  // Register offsets
  localparam logic [2:0] REG_DATA = 3'd0;  // RBR / THR / DLL
  localparam logic [2:0] REG_IER  = 3'd1;  // IER / DLM
  localparam logic [2:0] REG_IIR  = 3'd2;  // IIR (read) / FCR (write)
  localparam logic [2:0] REG_LCR  = 3'd3;
  localparam logic [2:0] REG_MCR  = 3'd4;
  localparam logic [2:0] REG_LSR  = 3'd5;
  localparam logic [2:0] REG_MSR  = 3'd6;
  localparam logic [2:0] REG_SCR  = 3'd7;

  localparam logic [3:0] ACCESS_ONE     = 4'd1;
  localparam logic [7:0] LCR_RESET      = 8'h03;
  localparam logic [7:0] IIR_RDA        = 8'hC4;
  localparam logic [7:0] IIR_THRE       = 8'hC2;
  localparam logic [7:0] IIR_NONE       = 8'hC1;
  localparam logic [7:0] LSR_BASE       = 8'h60;
  localparam logic [7:0] MSR_VALUE      = 8'h90;
  localparam int         DLAB_BIT       = 7;
  localparam int         FCR_RX_CLR_BIT = 1;
  localparam int         IER_RDA_BIT    = 0;
  localparam int         IER_THRE_BIT   = 1;

  typedef struct packed {
    logic [7:0] rx_char;
    logic [7:0] write_value;
    logic [3:0] access_bytes;
    logic [2:0] reg_offset;
    op_t        op;
  } req_t;

  // Packed lowest field last, so it maps straight onto tdata.
  typedef struct packed {
    logic       rx_dropped;
    logic       irq_pending;
    logic [7:0] tx_byte;
    logic       tx_valid;
    logic       access_ok;
    logic [7:0] read_value;
  } result_t;

  typedef struct packed {
    logic    from_fifo;  // read_value comes from the FIFO read port
    result_t res;
  } stage_t;

endpackage

// File: hw/rtl/uart_8250_register_model.sv
// Top level of the 8250-style UART register model.
// Depends on u8250_pkg, u8250_core and u8250_ram.
//
// Usage:
//  - Request channel (s_axis_*): one bus read, bus write or line character per
//    request. tuser carries the op; tdata carries offset, size, write byte and
//    received character.
//  - Result channel (m_axis_*): exactly one result per request, in order:
//    read data, access status, transmit byte strobe, interrupt line, drop flag.
//  - Pipeline: two register stages, stage one and the output register.
//    m_axis_tvalid rises when stage one hands on into the output register.
//    Stage one updates the registers and FIFO pointers and launches the
//    FIFO read; stage two merges the registered FIFO read data into the
//    output register.
//  - Throughput: one request per cycle while the result side keeps up; stage
//    one hands on in every cycle the output register is free or being taken.
//  - Reset (rst, synchronous): registers return to their 8250 reset values,
//    LCR = 0x03, FIFO empty, both pipeline stages empty. FIFO storage itself
//    is not cleared; only filled entries are ever read.
//  - Stall: with m_axis_tready low the output holds; one more request can sit
//    in stage one, after which s_axis_tready drops until the output drains.
module uart_8250_register_model #(
  parameter int RX_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata, low to high: reg_offset[2:0], access_bytes[6:3], write_value[14:7],
  // rx_char[22:15], zero [23]
  input  logic [23:0] s_axis_tdata,
  // tuser: op[1:0]
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tdata, low to high: read_value[7:0], access_ok[8], tx_valid[9],
  // tx_byte[17:10], irq_pending[18], rx_dropped[19], zero [23:20]
  output logic [23:0] m_axis_tdata
);

  localparam int PTR_W = RX_DEPTH > 1 ? $clog2(RX_DEPTH) : 1;

  u8250_pkg::req_t    req;
  u8250_pkg::stage_t  s1;
  u8250_pkg::result_t s1_res;
  u8250_pkg::result_t out_res;
  logic               s1_valid, s1_advance, in_accept;
  logic               ram_we, ram_re;
  logic [PTR_W-1:0]   ram_waddr, ram_raddr;
  logic [7:0]         ram_wdata, ram_rdata;

  // request unpack
  assign req.op           = u8250_pkg::op_t'(s_axis_tuser);
  assign req.reg_offset   = s_axis_tdata[2:0];
  assign req.access_bytes = s_axis_tdata[6:3];
  assign req.write_value  = s_axis_tdata[14:7];
  assign req.rx_char      = s_axis_tdata[22:15];

  // stage one moves on when the output register is free or being taken
  assign s1_advance    = s1_valid && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !s1_valid || s1_advance;
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  u8250_core #(
    .RX_DEPTH (RX_DEPTH)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .in_accept  (in_accept),
    .req        (req),
    .s1_advance (s1_advance),
    .s1_valid   (s1_valid),
    .s1         (s1),
    .ram_we     (ram_we),
    .ram_waddr  (ram_waddr),
    .ram_wdata  (ram_wdata),
    .ram_re     (ram_re),
    .ram_raddr  (ram_raddr)
  );

  // receive FIFO storage; read data holds until the next pop is launched, which
  // only happens once stage one is empty or drains into the output register
  u8250_ram #(
    .WIDTH (8),
    .DEPTH (RX_DEPTH)
  ) u_rx_fifo (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // RBR pops take their data from the RAM read port
  always_comb begin
    s1_res = s1.res;
    if (s1.from_fifo) begin
      s1_res.read_value = ram_rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (s1_advance) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      out_res <= s1_res;
    end
  end

  assign m_axis_tdata = {4'd0, out_res};

endmodule

// File: hw/rtl/u8250_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module u8250_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hw/rtl/u8250_core.sv
// Register file, FIFO pointers and request decode of the UART model.
// Depends on u8250_pkg; drives the FIFO storage RAM in the top level.
module u8250_core #(
  parameter int RX_DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_accept,
  input  u8250_pkg::req_t          req,
  input  logic                     s1_advance,
  output logic                     s1_valid,
  output u8250_pkg::stage_t        s1,
  output logic                     ram_we,
  output logic [(RX_DEPTH > 1 ? $clog2(RX_DEPTH) : 1)-1:0] ram_waddr,
  output logic [7:0]               ram_wdata,
  output logic                     ram_re,
  output logic [(RX_DEPTH > 1 ? $clog2(RX_DEPTH) : 1)-1:0] ram_raddr
);

  localparam int PTR_W = RX_DEPTH > 1 ? $clog2(RX_DEPTH) : 1;
  localparam int CNT_W = $clog2(RX_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(RX_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(RX_DEPTH);

  logic [7:0]       divisor_low, divisor_low_next;
  logic [7:0]       divisor_high, divisor_high_next;
  logic [7:0]       int_enable, int_enable_next;
  logic [7:0]       line_control, line_control_next;
  logic [7:0]       modem_control, modem_control_next;
  logic             tx_empty, tx_empty_next;
  logic [PTR_W-1:0] rx_head, rx_head_next;
  logic [PTR_W-1:0] rx_tail, rx_tail_next;
  logic [CNT_W-1:0] rx_count, rx_count_next;

  logic             dlab, fifo_ne, fifo_full;
  logic             is_rd, is_wr, is_rx, pop;
  logic [7:0]       iir_now;
  u8250_pkg::stage_t st;

  assign dlab      = line_control[u8250_pkg::DLAB_BIT];
  assign fifo_ne   = (rx_count != '0);
  assign fifo_full = (rx_count == CNT_FULL);

  assign is_rd = (req.op == u8250_pkg::OP_READ) && (req.access_bytes == u8250_pkg::ACCESS_ONE);
  assign is_wr = (req.op == u8250_pkg::OP_WRITE) && (req.access_bytes == u8250_pkg::ACCESS_ONE)
                 && (req.reg_offset <= u8250_pkg::REG_MCR);
  assign is_rx = (req.op == u8250_pkg::OP_RX);
  assign pop   = is_rd && (req.reg_offset == u8250_pkg::REG_DATA) && !dlab && fifo_ne;

  always_comb begin
    if (int_enable[u8250_pkg::IER_RDA_BIT] && fifo_ne) begin
      iir_now = u8250_pkg::IIR_RDA;
    end else if (int_enable[u8250_pkg::IER_THRE_BIT] && tx_empty) begin
      iir_now = u8250_pkg::IIR_THRE;
    end else begin
      iir_now = u8250_pkg::IIR_NONE;
    end
  end

  // FIFO storage ports
  assign ram_we    = in_accept && is_rx && !fifo_full;
  assign ram_waddr = rx_tail;
  assign ram_wdata = req.rx_char;
  assign ram_re    = in_accept && pop;
  assign ram_raddr = rx_head;

  // Next state
  always_comb begin
    divisor_low_next   = divisor_low;
    divisor_high_next  = divisor_high;
    int_enable_next    = int_enable;
    line_control_next  = line_control;
    modem_control_next = modem_control;
    tx_empty_next      = tx_empty;
    rx_head_next       = rx_head;
    rx_tail_next       = rx_tail;
    rx_count_next      = rx_count;
    if (is_rd) begin
      if (pop) begin
        rx_head_next  = (rx_head == PTR_LAST) ? '0 : rx_head + PTR_W'(1);
        rx_count_next = rx_count - CNT_W'(1);
      end
      if (req.reg_offset == u8250_pkg::REG_IIR) begin
        tx_empty_next = 1'b0;
      end
    end else if (is_wr) begin
      unique case (req.reg_offset)
        u8250_pkg::REG_DATA: begin
          if (dlab) begin
            divisor_low_next = req.write_value;
          end else begin
            tx_empty_next = 1'b1;
          end
        end
        u8250_pkg::REG_IER: begin
          if (dlab) begin
            divisor_high_next = req.write_value;
          end else begin
            int_enable_next = req.write_value;
          end
        end
        u8250_pkg::REG_IIR: begin
          if (req.write_value[u8250_pkg::FCR_RX_CLR_BIT]) begin
            rx_head_next  = '0;
            rx_tail_next  = '0;
            rx_count_next = '0;
          end
        end
        u8250_pkg::REG_LCR: line_control_next  = req.write_value;
        default:            modem_control_next = req.write_value;
      endcase
    end else if (is_rx && !fifo_full) begin
      rx_tail_next  = (rx_tail == PTR_LAST) ? '0 : rx_tail + PTR_W'(1);
      rx_count_next = rx_count + CNT_W'(1);
    end
  end

  // Result fields
  always_comb begin
    st = '0;
    st.from_fifo = pop;
    if (is_rd) begin
      st.res.access_ok = 1'b1;
      unique case (req.reg_offset)
        u8250_pkg::REG_DATA: st.res.read_value = dlab ? divisor_low : 8'h00;
        u8250_pkg::REG_IER:  st.res.read_value = dlab ? divisor_high : int_enable;
        u8250_pkg::REG_IIR:  st.res.read_value = iir_now;
        u8250_pkg::REG_LCR:  st.res.read_value = line_control;
        u8250_pkg::REG_MCR:  st.res.read_value = modem_control;
        u8250_pkg::REG_LSR:  st.res.read_value = u8250_pkg::LSR_BASE | {7'd0, fifo_ne};
        u8250_pkg::REG_MSR:  st.res.read_value = u8250_pkg::MSR_VALUE;
        u8250_pkg::REG_SCR:  st.res.read_value = 8'h00;
        default:             st.res.read_value = 8'h00;
      endcase
    end else if (is_wr) begin
      st.res.access_ok = 1'b1;
      if (req.reg_offset == u8250_pkg::REG_DATA && !dlab) begin
        st.res.tx_valid = 1'b1;
        st.res.tx_byte  = req.write_value;
      end
    end else if (is_rx) begin
      st.res.access_ok  = !fifo_full;
      st.res.rx_dropped = fifo_full;
    end
    // interrupt line as it stands after this request
    st.res.irq_pending =
      (int_enable_next[u8250_pkg::IER_RDA_BIT] && (rx_count_next != '0)) ||
      (int_enable_next[u8250_pkg::IER_THRE_BIT] && tx_empty_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      divisor_low   <= '0;
      divisor_high  <= '0;
      int_enable    <= '0;
      line_control  <= u8250_pkg::LCR_RESET;
      modem_control <= '0;
      tx_empty      <= 1'b0;
      rx_head       <= '0;
      rx_tail       <= '0;
      rx_count      <= '0;
      s1_valid      <= 1'b0;
    end else begin
      if (in_accept) begin
        divisor_low   <= divisor_low_next;
        divisor_high  <= divisor_high_next;
        int_enable    <= int_enable_next;
        line_control  <= line_control_next;
        modem_control <= modem_control_next;
        tx_empty      <= tx_empty_next;
        rx_head       <= rx_head_next;
        rx_tail       <= rx_tail_next;
        rx_count      <= rx_count_next;
        s1_valid      <= 1'b1;
      end else if (s1_advance) begin
        s1_valid      <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1 <= st;
    end
  end

endmodule

// File: hw/rtl/u8250_checker.sv
// Port-level checker for the UART register model, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module u8250_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata
);

  // output empty right after reset
  `ASSERT_ALWAYS_NEXT(a_reset_empty, clk, rst, !m_axis_tvalid)

  // stalled result holds
  `ASSERT_NEXT(a_stall_hold, clk, rst, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

  // a transmitted byte only comes with an accepted write
  `ASSERT_NOW(a_tx_ok, clk, rst, m_axis_tvalid && m_axis_tdata[9], m_axis_tdata[8] && (m_axis_tdata[7:0] == 8'h00))

  // tx_byte is zero without tx_valid
  `ASSERT_NOW(a_tx_zero, clk, rst, m_axis_tvalid && !m_axis_tdata[9], m_axis_tdata[17:10] == 8'h00)

  // a dropped character is never reported as accepted
  `ASSERT_NOW(a_drop_nok, clk, rst, m_axis_tvalid && m_axis_tdata[19], !m_axis_tdata[8] && !m_axis_tdata[9])

endmodule

bind uart_8250_register_model u8250_checker u_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

// File: verif/uart_8250_register_model_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for the 8250-style UART register model.
// Depends on u8250_pkg and uart_8250_register_model; a scoreboard class
// shadows the UART registers and receive FIFO and checks each result in order.
module uart_8250_register_model_test;

  localparam int RX_DEPTH    = 16;
  localparam int ITEMS       = 1950;
  localparam int QUIET_TAIL  = 250;   // last requests run with no idling
  localparam int HOLD_CYCLES = 120;   // long result-side stall
  localparam int PRINT_CAP   = 40;    // mismatch lines printed before going quiet

  // Shadow of the UART: register file, transmit-empty flag and receive FIFO.
  // note_request() advances the shadow for each accepted request and queues
  // the result it must produce; check_result() compares what came out.
  class uart_scoreboard;
    logic [7:0] dll, dlm, ier, lcr, mcr;
    bit         thre_flag;
    logic [7:0] rx_mem [RX_DEPTH];
    int         rd_ptr, wr_ptr, fill;
    u8250_pkg::result_t expected_q [$];
    int         mismatches, checked, drops, tx_bytes;

    function new();
      dll = '0;
      dlm = '0;
      ier = '0;
      lcr = u8250_pkg::LCR_RESET;
      mcr = '0;
      thre_flag = 1'b0;
      rd_ptr = 0;
      wr_ptr = 0;
      fill = 0;
    endfunction

    // RDA outranks THRE
    function logic [7:0] interrupt_id();
      if (ier[u8250_pkg::IER_RDA_BIT] && fill != 0) return u8250_pkg::IIR_RDA;
      if (ier[u8250_pkg::IER_THRE_BIT] && thre_flag) return u8250_pkg::IIR_THRE;
      return u8250_pkg::IIR_NONE;
    endfunction

    // Read side effects: RBR pops the FIFO, IIR clears the THRE flag.
    function logic [7:0] read_register(logic [2:0] off);
      logic [7:0] v;
      v = '0;
      case (off)
        u8250_pkg::REG_DATA: begin
          if (lcr[u8250_pkg::DLAB_BIT]) begin
            v = dll;
          end else if (fill != 0) begin
            v = rx_mem[rd_ptr];
            rd_ptr = (rd_ptr + 1) % RX_DEPTH;
            fill--;
          end
        end
        u8250_pkg::REG_IER: v = lcr[u8250_pkg::DLAB_BIT] ? dlm : ier;
        u8250_pkg::REG_IIR: begin
          v = interrupt_id();
          thre_flag = 1'b0;
        end
        u8250_pkg::REG_LCR: v = lcr;
        u8250_pkg::REG_MCR: v = mcr;
        u8250_pkg::REG_LSR: v = u8250_pkg::LSR_BASE | {7'd0, fill != 0};
        u8250_pkg::REG_MSR: v = u8250_pkg::MSR_VALUE;
        default: v = '0;
      endcase
      return v;
    endfunction

    function void note_request(u8250_pkg::req_t r);
      u8250_pkg::result_t res;
      logic [7:0]         id;
      res = '0;
      case (r.op)
        u8250_pkg::OP_READ: begin
          if (r.access_bytes == u8250_pkg::ACCESS_ONE) begin
            res.read_value = read_register(r.reg_offset);
            res.access_ok  = 1'b1;
          end
        end
        u8250_pkg::OP_WRITE: begin
          if (r.access_bytes == u8250_pkg::ACCESS_ONE &&
              r.reg_offset <= u8250_pkg::REG_MCR) begin
            res.access_ok = 1'b1;
            case (r.reg_offset)
              u8250_pkg::REG_DATA: begin
                if (lcr[u8250_pkg::DLAB_BIT]) begin
                  dll = r.write_value;
                end else begin
                  res.tx_valid = 1'b1;
                  res.tx_byte  = r.write_value;
                  thre_flag    = 1'b1;
                  tx_bytes++;
                end
              end
              u8250_pkg::REG_IER: begin
                if (lcr[u8250_pkg::DLAB_BIT]) dlm = r.write_value;
                else ier = r.write_value;
              end
              u8250_pkg::REG_IIR: begin
                // FCR: only the receive-clear bit does anything
                if (r.write_value[u8250_pkg::FCR_RX_CLR_BIT]) begin
                  rd_ptr = 0;
                  wr_ptr = 0;
                  fill   = 0;
                end
              end
              u8250_pkg::REG_LCR: lcr = r.write_value;
              default: mcr = r.write_value;
            endcase
          end
        end
        u8250_pkg::OP_RX: begin
          if (fill >= RX_DEPTH) begin
            res.rx_dropped = 1'b1;
            drops++;
          end else begin
            rx_mem[wr_ptr] = r.rx_char;
            wr_ptr = (wr_ptr + 1) % RX_DEPTH;
            fill++;
            res.access_ok = 1'b1;
          end
        end
        default: ;
      endcase
      id = interrupt_id();
      res.irq_pending = ~id[0];
      expected_q.push_back(res);
    endfunction

    task report(string msg);
      if (mismatches < PRINT_CAP) $display("MISMATCH: %s", msg);
      mismatches++;
    endtask

    task check_result(logic [23:0] data);
      u8250_pkg::result_t got, want;
      got = u8250_pkg::result_t'(data[19:0]);
      checked++;
      if (expected_q.size() == 0) begin
        report($sformatf("result %0d arrived with nothing expected", checked));
        return;
      end
      want = expected_q.pop_front();
      if (got.read_value !== want.read_value)
        report($sformatf("result %0d read_value %h, want %h", checked,
                         got.read_value, want.read_value));
      if (got.access_ok !== want.access_ok)
        report($sformatf("result %0d access_ok %b, want %b", checked,
                         got.access_ok, want.access_ok));
      if (got.tx_valid !== want.tx_valid)
        report($sformatf("result %0d tx_valid %b, want %b", checked,
                         got.tx_valid, want.tx_valid));
      if (got.tx_byte !== want.tx_byte)
        report($sformatf("result %0d tx_byte %h, want %h", checked,
                         got.tx_byte, want.tx_byte));
      if (got.irq_pending !== want.irq_pending)
        report($sformatf("result %0d irq_pending %b, want %b", checked,
                         got.irq_pending, want.irq_pending));
      if (got.rx_dropped !== want.rx_dropped)
        report($sformatf("result %0d rx_dropped %b, want %b", checked,
                         got.rx_dropped, want.rx_dropped));
      if (data[23:20] !== 4'd0)
        report($sformatf("result %0d pad bits %b, want 0", checked, data[23:20]));
    endtask
  endclass

  logic        clk;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;

  uart_scoreboard sb = new();
  int sent;
  bit no_idle;        // final stretch: neither side idles
  bit burst;          // sender suppresses gaps while filling under a stall
  bit hold_off_req;   // stimulus asks the receiver for a long stall
  bit hold_active;    // receiver is in that stall
  bit pressure_done;

  uart_8250_register_model #(.RX_DEPTH(RX_DEPTH)) dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop; the slowest legal run is well under a tenth of this.
  initial begin
    #5_000_000;
    $display("uart_8250_register_model verification failed");
    $finish;
  end

  // One request on the slave side. Fields the op does not use get random
  // content so the block is seen to ignore them. Returns in the time step of
  // the accepting edge, so the next call can drive without a dead cycle.
  task issue(u8250_pkg::op_t op, logic [2:0] off, logic [3:0] size, logic [7:0] data);
    u8250_pkg::req_t r;
    r.op           = op;
    r.reg_offset   = off;
    r.access_bytes = size;
    r.write_value  = (op == u8250_pkg::OP_WRITE) ? data : 8'($urandom_range(0, 255));
    r.rx_char      = (op == u8250_pkg::OP_RX) ? data : 8'($urandom_range(0, 255));
    if (!no_idle && !burst && $urandom_range(0, 9) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= r.op;
    s_axis_tdata  <= {1'b0, r.rx_char, r.write_value, r.access_bytes, r.reg_offset};
    do @(posedge clk); while (!s_axis_tready);
    sb.note_request(r);
    sent++;
  endtask

  task wr(logic [2:0] off, logic [7:0] val);
    issue(u8250_pkg::OP_WRITE, off, u8250_pkg::ACCESS_ONE, val);
  endtask

  task rd(logic [2:0] off);
    issue(u8250_pkg::OP_READ, off, u8250_pkg::ACCESS_ONE, 8'd0);
  endtask

  // offset and size are don't-cares for a line character
  task rx(logic [7:0] c);
    issue(u8250_pkg::OP_RX, 3'($urandom_range(0, 7)), 4'($urandom_range(0, 15)), c);
  endtask

  task random_sequence();
    int n;
    case ($urandom_range(0, 6))
      0, 1: begin
        // fill from the line (often past full), then drain through RBR
        if ($urandom_range(0, 4) != 0)
          wr(u8250_pkg::REG_LCR, {1'b0, 7'($urandom_range(0, 127))});
        if ($urandom_range(0, 1) == 0) wr(u8250_pkg::REG_IER, 8'($urandom_range(0, 255)));
        n = $urandom_range(1, 20);
        repeat (n) rx(8'($urandom_range(0, 255)));
        n = $urandom_range(1, 20);
        repeat (n) begin
          if ($urandom_range(0, 3) == 0) rd(u8250_pkg::REG_LSR);
          else if ($urandom_range(0, 5) == 0) rd(u8250_pkg::REG_IIR);
          else rd(u8250_pkg::REG_DATA);
        end
      end
      2: begin
        // divisor latch access under DLAB, then back to the data bank
        wr(u8250_pkg::REG_LCR, {1'b1, 7'($urandom_range(0, 127))});
        wr(u8250_pkg::REG_DATA, 8'($urandom_range(0, 255)));
        wr(u8250_pkg::REG_IER, 8'($urandom_range(0, 255)));
        rd(u8250_pkg::REG_DATA);
        rd(u8250_pkg::REG_IER);
        rd(u8250_pkg::REG_LCR);
        wr(u8250_pkg::REG_LCR, {1'b0, 7'($urandom_range(0, 127))});
        rd(u8250_pkg::REG_IER);
      end
      3: begin
        // interrupt identification with both sources in play
        wr(u8250_pkg::REG_IER, 8'($urandom_range(0, 255)));
        if ($urandom_range(0, 1) == 0) wr(u8250_pkg::REG_DATA, 8'($urandom_range(0, 255)));
        if ($urandom_range(0, 1) == 0) rx(8'($urandom_range(0, 255)));
        n = $urandom_range(1, 3);
        repeat (n) rd(u8250_pkg::REG_IIR);
        if ($urandom_range(0, 1) == 0) rd(u8250_pkg::REG_DATA);
      end
      4: begin
        // FCR write, receive-clear bit random
        wr(u8250_pkg::REG_IIR, 8'($urandom_range(0, 255)));
        rd(u8250_pkg::REG_LSR);
        rd(u8250_pkg::REG_DATA);
      end
      5: begin
        wr(u8250_pkg::REG_MCR, 8'($urandom_range(0, 255)));
        rd(u8250_pkg::REG_MCR);
        rd(u8250_pkg::REG_MSR);
        rd(u8250_pkg::REG_SCR);
      end
      default: begin
        // noise: any op, offset and size, including refused accesses
        n = $urandom_range(1, 6);
        repeat (n)
          issue(u8250_pkg::op_t'($urandom_range(0, 3)), 3'($urandom_range(0, 7)),
                ($urandom_range(0, 1) == 0) ? u8250_pkg::ACCESS_ONE
                                            : 4'($urandom_range(0, 15)),
                8'($urandom_range(0, 255)));
      end
    endcase
  endtask

  // Result side: ready runs and stall bursts, one long stall on request,
  // always ready in the final stretch.
  initial begin
    wait (!rst);
    forever begin
      if (hold_off_req) begin
        m_axis_tready <= 1'b0;
        hold_active = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_active  = 1'b0;
        hold_off_req = 1'b0;
      end else if (no_idle) begin
        m_axis_tready <= 1'b1;
        @(posedge clk);
      end else begin
        m_axis_tready <= 1'b1;
        repeat ($urandom_range(1, 40)) @(posedge clk);
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end
    end
  end

  // Result monitor; sampled values are the ones before this edge's updates.
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
  end

  initial begin
    int guard;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed: reset values, every offset, both interrupt sources,
    // the DLAB bank, refused sizes and offsets, the unused op, FIFO clear.
    rd(u8250_pkg::REG_LCR);
    rd(u8250_pkg::REG_IIR);
    rd(u8250_pkg::REG_DATA);                 // empty FIFO reads as zero
    rd(u8250_pkg::REG_LSR);
    rd(u8250_pkg::REG_MSR);
    rd(u8250_pkg::REG_SCR);
    wr(u8250_pkg::REG_IER, 8'h03);
    wr(u8250_pkg::REG_DATA, 8'hFF);          // THR write raises THRE
    rd(u8250_pkg::REG_IIR);                  // reports THRE and clears it
    rx(8'h00);
    rd(u8250_pkg::REG_IIR);                  // RDA
    rd(u8250_pkg::REG_DATA);
    wr(u8250_pkg::REG_LCR, 8'h83);
    wr(u8250_pkg::REG_DATA, 8'hFF);          // DLL
    wr(u8250_pkg::REG_IER, 8'h80);           // DLM
    rd(u8250_pkg::REG_DATA);
    rd(u8250_pkg::REG_IER);
    wr(u8250_pkg::REG_LCR, 8'h03);
    wr(u8250_pkg::REG_MCR, 8'h1F);
    rd(u8250_pkg::REG_MCR);
    issue(u8250_pkg::OP_READ, u8250_pkg::REG_LCR, 4'h0, 8'h00);     // size zero
    issue(u8250_pkg::OP_WRITE, u8250_pkg::REG_DATA, 4'hF, 8'h5A);   // oversize write to THR
    issue(u8250_pkg::OP_WRITE, u8250_pkg::REG_SCR, 4'h8, 8'hFF);    // bad size, read-only
    wr(u8250_pkg::REG_LSR, 8'hFF);                                  // read-only offset
    issue(u8250_pkg::OP_NONE, u8250_pkg::REG_DATA, u8250_pkg::ACCESS_ONE, 8'hFF);
    rx(8'hAA);
    wr(u8250_pkg::REG_IIR, 8'h02);                                  // FCR receive clear
    rd(u8250_pkg::REG_LSR);

    while (sent < ITEMS) begin
      if (!pressure_done && sent >= 500) begin
        // Stall the result side and keep feeding characters until the
        // pipeline backs up into s_axis_tready.
        pressure_done = 1'b1;
        s_axis_tvalid <= 1'b0;
        hold_off_req = 1'b1;
        wait (hold_active);
        burst = 1'b1;
        repeat (30) rx(8'($urandom_range(0, 255)));
        burst = 1'b0;
      end
      if (sent >= ITEMS - QUIET_TAIL) no_idle = 1'b1;
      random_sequence();
    end
    s_axis_tvalid <= 1'b0;

    guard = 0;
    while (sb.expected_q.size() != 0 && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    repeat (8) @(posedge clk);   // room for any stray extra result
    if (sb.expected_q.size() != 0)
      sb.report($sformatf("%0d results never arrived", sb.expected_q.size()));

    $display("Sent %0d requests, checked %0d results: %0d THR bytes, %0d characters dropped",
             sent, sb.checked, sb.tx_bytes, sb.drops);
    $display("Mismatches: %0d", sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("uart_8250_register_model verification clean");
    end else begin
      $display("uart_8250_register_model verification failed");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+hw/rtl
hw/rtl/u8250_pkg.sv
hw/rtl/u8250_ram.sv
hw/rtl/u8250_core.sv
hw/rtl/uart_8250_register_model.sv
hw/rtl/u8250_checker.sv
verif/uart_8250_register_model_test.sv
